// File: hdl/rle_byte_encoder_defines.svh
// ----------------------------------------------------------------------------
// RLE byte encoder assertion macros
// Shared property wrappers, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RLE_BYTE_ENCODER_DEFINES_SVH
`define RLE_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define RLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rle_pkg.sv
// ----------------------------------------------------------------------------
// RLE encoder package
// Sizes, block and command types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

    localparam int LIT_DEPTH  = 128;               // longest literal run
    localparam int MAX_REPEAT = 129;               // longest repeat run
    localparam int OUT_LANES  = 8;                 // bytes per output beat
    localparam int LANE_BITS  = $clog2(OUT_LANES);
    localparam int CNT_W      = 8;                 // run length / byte counts
    localparam int LV_W       = 4;                 // lanes_valid width
    // literal byte i sits at position i + 1; position 0 is the header slot
    localparam int ROWS       = (LIT_DEPTH + OUT_LANES) / OUT_LANES;
    localparam int ROW_BITS   = $clog2(ROWS);

    localparam logic [CNT_W-1:0] REPEAT_HDR_OFS = CNT_W'(126);

    typedef enum logic [3:0] {
        MODE_EMPTY   = 4'b0001,
        MODE_HELD    = 4'b0010,
        MODE_REPEAT  = 4'b0100,
        MODE_LITERAL = 4'b1000
    } run_mode_t;

    typedef enum logic {
        BLK_REPEAT  = 1'b0,
        BLK_LITERAL = 1'b1
    } blk_kind_t;

    // one coded block: repeat (len = run length) or literal (len = byte count)
    typedef struct packed {
        blk_kind_t        kind;
        logic [CNT_W-1:0] len;
        logic [7:0]       value;
    } blk_t;

    typedef struct packed {
        logic load;      // take the input byte, update run state
        logic read;      // fetch the current group's store row
        logic advance;   // current beat taken, step to the next group
    } rle_cmd_t;

    typedef struct packed {
        logic plan_any;  // the byte being offered produces at least one beat
        logic grp_last;  // the current beat is the last for this byte
    } rle_sts_t;

endpackage

`default_nettype wire

// File: hdl/rle_dp.sv
// ----------------------------------------------------------------------------
// RLE encoder datapath
// Run state, literal store, block plan and beat assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_dp
    import rle_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       final_byte,
    input  wire rle_cmd_t                   cmd,
    output rle_sts_t                        sts,
    output logic [OUT_LANES-1:0][7:0]       lanes,
    output logic [LV_W-1:0]                 lanes_valid,
    output logic                            group_last
);

    run_mode_t        mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [CNT_W-1:0] rl_reg, rl_next;
    logic [7:0]       last_reg, last_next;

    blk_t             cur_reg, nxt_reg;
    logic             has_next_reg;
    logic [ROW_BITS-1:0] grp_reg;
    logic [7:0]       rd_row_reg [OUT_LANES];

    logic [7:0]       lit_mem [ROWS][OUT_LANES];

    logic                  a_valid, b_valid;
    blk_t                  a_blk, b_blk;
    logic [OUT_LANES-1:0]  wr_en;
    logic [ROW_BITS-1:0]   wr_row;
    logic [7:0]            wr_data [OUT_LANES];
    logic [CNT_W-1:0]      lit_pos;

    logic [CNT_W-1:0]      blk_total, blk_base, blk_remain;
    logic [7:0]            blk_hdr;
    logic                  blk_last;

    // ---------------- run state update for one byte ----------------
    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        rl_next   = rl_reg;
        last_next = last_reg;
        wr_en     = '0;
        wr_row    = '0;
        for (int j = 0; j < OUT_LANES; j++) begin
            wr_data[j] = data_byte;
        end
        lit_pos       = rl_reg + CNT_W'(1);
        a_valid       = 1'b0;
        a_blk.kind    = BLK_REPEAT;
        a_blk.len     = rl_reg;
        a_blk.value   = held_reg;
        b_valid       = 1'b0;
        b_blk         = a_blk;

        unique case (mode_reg)
            MODE_EMPTY: begin
                held_next = data_byte;
                mode_next = MODE_HELD;
            end
            MODE_HELD: begin
                if (data_byte == held_reg) begin
                    rl_next   = CNT_W'(2);
                    mode_next = MODE_REPEAT;
                end else begin
                    wr_en[1]   = 1'b1;
                    wr_en[2]   = 1'b1;
                    wr_data[1] = held_reg;
                    rl_next    = CNT_W'(2);
                    last_next  = data_byte;
                    mode_next  = MODE_LITERAL;
                    if (LIT_DEPTH <= 2) begin
                        a_valid    = 1'b1;
                        a_blk.kind = BLK_LITERAL;
                        a_blk.len  = CNT_W'(2);
                        mode_next  = MODE_EMPTY;
                        rl_next    = '0;
                    end
                end
            end
            MODE_REPEAT: begin
                if (data_byte == held_reg) begin
                    rl_next = rl_reg + CNT_W'(1);
                    if (rl_next >= CNT_W'(MAX_REPEAT)) begin
                        a_valid   = 1'b1;
                        a_blk.len = rl_next;
                        mode_next = MODE_EMPTY;
                        rl_next   = '0;
                    end
                end else begin
                    a_valid   = 1'b1;
                    held_next = data_byte;
                    rl_next   = '0;
                    mode_next = MODE_HELD;
                end
            end
            MODE_LITERAL: begin
                if (rl_reg >= CNT_W'(2) && rl_reg < CNT_W'(LIT_DEPTH) &&
                    data_byte == last_reg) begin
                    // pair closes the literal; its last byte opens a repeat
                    a_valid    = 1'b1;
                    a_blk.kind = BLK_LITERAL;
                    a_blk.len  = rl_reg - CNT_W'(1);
                    held_next  = data_byte;
                    rl_next    = CNT_W'(2);
                    mode_next  = MODE_REPEAT;
                end else begin
                    if (rl_reg < CNT_W'(LIT_DEPTH)) begin
                        wr_en[lit_pos[LANE_BITS-1:0]] = 1'b1;
                        wr_row    = ROW_BITS'(lit_pos >> LANE_BITS);
                        rl_next   = lit_pos;
                        last_next = data_byte;
                    end
                    if (rl_next >= CNT_W'(LIT_DEPTH)) begin
                        a_valid    = 1'b1;
                        a_blk.kind = BLK_LITERAL;
                        a_blk.len  = rl_next;
                        mode_next  = MODE_EMPTY;
                        rl_next    = '0;
                    end
                end
            end
            default: begin
                mode_next = MODE_EMPTY;
                rl_next   = '0;
            end
        endcase

        // flush whatever is pending after a final byte
        if (final_byte) begin
            case (mode_next)
                MODE_HELD: begin
                    wr_en[1]    = 1'b1;
                    wr_row      = '0;
                    wr_data[1]  = held_next;
                    b_valid     = 1'b1;
                    b_blk.kind  = BLK_LITERAL;
                    b_blk.len   = CNT_W'(1);
                    b_blk.value = held_next;
                end
                MODE_REPEAT: begin
                    b_valid     = 1'b1;
                    b_blk.kind  = BLK_REPEAT;
                    b_blk.len   = rl_next;
                    b_blk.value = held_next;
                end
                MODE_LITERAL: begin
                    b_valid     = 1'b1;
                    b_blk.kind  = BLK_LITERAL;
                    b_blk.len   = rl_next;
                    b_blk.value = held_next;
                end
                default: begin
                end
            endcase
            mode_next = MODE_EMPTY;
            rl_next   = '0;
        end
    end

    // ---------------- run state and block plan ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_EMPTY;
            held_reg     <= '0;
            rl_reg       <= '0;
            has_next_reg <= 1'b0;
            grp_reg      <= '0;
        end else begin
            if (cmd.load) begin
                mode_reg     <= mode_next;
                held_reg     <= held_next;
                rl_reg       <= rl_next;
                has_next_reg <= a_valid & b_valid;
                grp_reg      <= '0;
            end else if (cmd.advance) begin
                if (blk_last) begin
                    grp_reg      <= '0;
                    has_next_reg <= 1'b0;
                end else begin
                    grp_reg <= grp_reg + ROW_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg <= last_next;
            cur_reg  <= a_valid ? a_blk : b_blk;
            nxt_reg  <= b_blk;
        end else if (cmd.advance && blk_last && has_next_reg) begin
            cur_reg <= nxt_reg;
        end
    end

    // ---------------- literal store, one row per output beat ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int j = 0; j < OUT_LANES; j++) begin
                if (wr_en[j]) begin
                    lit_mem[wr_row][j] <= wr_data[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            for (int j = 0; j < OUT_LANES; j++) begin
                rd_row_reg[j] <= lit_mem[grp_reg][j];
            end
        end
    end

    // ---------------- beat assembly ----------------
    always_comb begin
        blk_total  = (cur_reg.kind == BLK_REPEAT) ? CNT_W'(2) : cur_reg.len + CNT_W'(1);
        blk_base   = CNT_W'({grp_reg, {LANE_BITS{1'b0}}});
        blk_remain = blk_total - blk_base;
        blk_last   = (blk_remain <= CNT_W'(OUT_LANES));
        blk_hdr    = (cur_reg.kind == BLK_REPEAT) ? cur_reg.len + REPEAT_HDR_OFS
                                                  : cur_reg.len - CNT_W'(1);
        lanes_valid = blk_last ? LV_W'(blk_remain) : LV_W'(OUT_LANES);
        for (int j = 0; j < OUT_LANES; j++) begin
            if (LV_W'(j) >= lanes_valid) begin
                lanes[j] = '0;
            end else if (grp_reg == '0 && j == 0) begin
                lanes[j] = blk_hdr;
            end else if (cur_reg.kind == BLK_REPEAT) begin
                lanes[j] = cur_reg.value;
            end else begin
                lanes[j] = rd_row_reg[j];
            end
        end
        group_last   = blk_last & ~has_next_reg;
        sts.grp_last = group_last;
        sts.plan_any = a_valid | b_valid;
    end

endmodule

`default_nettype wire

// File: hdl/rle_ctrl.sv
// ----------------------------------------------------------------------------
// RLE encoder controller
// Sequences byte intake, store row fetch and output beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rle_byte_encoder_defines.svh"

module rle_ctrl
    import rle_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output rle_cmd_t      cmd,
    input  wire rle_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (sts.plan_any) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    state_next  = sts.grp_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RLE_ASSERT_NOW(a_no_intake_while_sending, m_tvalid, !s_tready, "input taken during output")
    `RLE_ASSERT_NEXT(a_idle_after_last_beat, m_tvalid && m_tready && sts.grp_last, s_tready,
        "not ready after last beat")
    `RLE_ASSERT_NEXT(a_silent_byte_stays_idle, s_tvalid && s_tready && !sts.plan_any, s_tready,
        "left idle on a byte with no output")

endmodule

`default_nettype wire

// File: hdl/rle_byte_encoder.sv
// ----------------------------------------------------------------------------
// RLE byte encoder (PackBits style), stream top level
// A byte that produces no output leaves the controller idle, ready for the next byte.
// A byte that produces output: each beat takes a store row read, then a send that
// waits for m_tready; the next byte is taken only after the last beat is sent.
// Reset (aresetn low, synchronous) empties the run state; store contents stay.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_byte_encoder
    import rle_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tlast,   // final_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_LANES*8-1:0]      m_tdata,   // out_lane_0 .. out_lane_7, 8 bits each
    output logic [LV_W-1:0]             m_tuser,   // [3:0] lanes_valid
    output logic                        m_tlast    // group_last
);

    rle_cmd_t                  cmd;
    rle_sts_t                  sts;
    logic [OUT_LANES-1:0][7:0] lanes;

    rle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rle_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_tdata),
        .final_byte  (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .lanes       (lanes),
        .lanes_valid (m_tuser),
        .group_last  (m_tlast)
    );

    assign m_tdata = lanes;

endmodule

`default_nettype wire

// File: tb/rle_byte_encoder_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RLE byte encoder stream checker
// Watches both stream channels, codes every accepted input byte with its own
// run-length encoder and compares each output beat with the oldest expected
// group, lane by lane, plus lanes_valid and group_last.
// ----------------------------------------------------------------------------

module rle_byte_encoder_check
    import rle_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tlast,   // final_byte
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_LANES*8-1:0] m_tdata,   // out_lane_0 .. out_lane_7, 8 bits each
    input  wire logic [LV_W-1:0]        m_tuser,   // [3:0] lanes_valid
    input  wire logic                   m_tlast,   // group_last
    output int                          errors,
    output int                          queued
);

    typedef struct packed {
        logic [OUT_LANES*8-1:0] lanes;
        logic [LV_W-1:0]        count;
        logic                   last;
    } coded_beat_t;

    coded_beat_t      coded_q [$];
    run_mode_t        mode = MODE_EMPTY;
    logic [7:0]       held = '0;
    logic [CNT_W-1:0] run_len = '0;
    logic [7:0]       lit_bytes [LIT_DEPTH];
    logic [7:0]       blk_bytes [LIT_DEPTH+1];
    int               blk_len;
    int               mismatches = 0;
    int               depth = 0;

    assign errors = mismatches;
    assign queued = depth;

    // split one coded block into groups of up to OUT_LANES bytes
    function automatic void push_block();
        coded_beat_t beat;
        int n;
        for (int pos = 0; pos < blk_len; pos += OUT_LANES) begin
            n = (blk_len - pos < OUT_LANES) ? blk_len - pos : OUT_LANES;
            beat = '0;
            for (int j = 0; j < n; j++) begin
                beat.lanes[j*8 +: 8] = blk_bytes[pos + j];
            end
            beat.count = LV_W'(n);
            coded_q.push_back(beat);
        end
    endfunction

    function automatic void push_repeat();
        blk_bytes[0] = run_len + REPEAT_HDR_OFS;
        blk_bytes[1] = held;
        blk_len = 2;
        push_block();
    endfunction

    function automatic void push_literal(input int cnt);
        blk_bytes[0] = 8'(cnt - 1);
        for (int i = 0; i < cnt; i++) begin
            blk_bytes[i + 1] = lit_bytes[i];
        end
        blk_len = cnt + 1;
        push_block();
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        int start_size;
        start_size = coded_q.size();
        case (mode)
            MODE_EMPTY: begin
                held = b;
                mode = MODE_HELD;
            end
            MODE_HELD: begin
                run_len = 2;
                if (b == held) begin
                    mode = MODE_REPEAT;
                end else begin
                    lit_bytes[0] = held;
                    lit_bytes[1] = b;
                    mode = MODE_LITERAL;
                end
            end
            MODE_REPEAT: begin
                if (b == held) begin
                    run_len++;
                    if (run_len >= MAX_REPEAT) begin
                        push_repeat();
                        mode = MODE_EMPTY;
                        run_len = 0;
                    end
                end else begin
                    push_repeat();
                    held = b;
                    run_len = 0;
                    mode = MODE_HELD;
                end
            end
            default: begin
                // a pair closes the literal; its last byte moves into a repeat
                if (run_len < LIT_DEPTH && b == lit_bytes[run_len - 1]) begin
                    push_literal(int'(run_len) - 1);
                    held = b;
                    run_len = 2;
                    mode = MODE_REPEAT;
                end else begin
                    if (run_len < LIT_DEPTH) begin
                        lit_bytes[run_len] = b;
                        run_len++;
                    end
                    if (run_len >= LIT_DEPTH) begin
                        push_literal(int'(run_len));
                        mode = MODE_EMPTY;
                        run_len = 0;
                    end
                end
            end
        endcase
        if (fin) begin
            case (mode)
                MODE_HELD: begin
                    lit_bytes[0] = held;
                    push_literal(1);
                end
                MODE_REPEAT:  push_repeat();
                MODE_LITERAL: push_literal(int'(run_len));
                default: ;
            endcase
            mode = MODE_EMPTY;
            run_len = 0;
        end
        if (coded_q.size() > start_size) begin
            coded_q[coded_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        coded_beat_t want;
        if (!aresetn) begin
            mode = MODE_EMPTY;
            held = '0;
            run_len = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (coded_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got %h/%0d/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = coded_q.pop_front();
                    for (int j = 0; j < OUT_LANES; j++) begin
                        if (m_tdata[j*8 +: 8] !== want.lanes[j*8 +: 8]) begin
                            note_mismatch($sformatf("lane %0d", j), want.lanes[j*8 +: 8],
                                          m_tdata[j*8 +: 8]);
                        end
                    end
                    if (m_tuser !== want.count) begin
                        note_mismatch("lanes_valid", want.count, m_tuser);
                    end
                    if (m_tlast !== want.last) begin
                        note_mismatch("group_last", want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
            end
        end
        depth = coded_q.size();
    end

endmodule

// File: tb/rle_byte_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RLE byte encoder testbench
// Feeds byte streams of repeat runs, literal runs and noise, with random gaps
// on the input and random stalls on the output, and reports the verdict of
// the stream checker.
// ----------------------------------------------------------------------------

module rle_byte_encoder_test;
    import rle_pkg::*;

    localparam int ITEMS      = 370;
    localparam int IDLE_LIMIT = 2000;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_LANES*8-1:0] m_tdata;
    logic [LV_W-1:0]        m_tuser;
    logic                   m_tlast;

    int   errors;
    int   queued;
    int   sent = 0;
    int   stall = 0;
    int   idle_cycles = 0;
    logic steady = 1'b0;

    rle_byte_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rle_byte_encoder_check i_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .queued   (queued)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_draw();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // output side: after each beat hold tready low for a random number of cycles
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall <= 0;
        end else if (m_tvalid && m_tready) begin
            w = idle_draw();
            stall <= w;
            m_tready <= (w == 0);
        end else if (stall > 0) begin
            stall <= stall - 1;
            if (stall == 1) begin
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // keep tvalid high across back-to-back beats; drop it only for a gap
    task automatic send_byte(input logic [7:0] value, input logic fin);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_repeat(input int len, input logic fin_end);
        logic [7:0] value;
        value = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            send_byte(value, fin_end && i == len - 1);
        end
    endtask

    // neighbors always differ, so the run stays literal; pair_end adds a twin
    task automatic send_literal(input int len, input logic pair_end, input logic fin_end);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                b = b + 8'($urandom_range(1, 255));
            end
            send_byte(b, fin_end && !pair_end && i == len - 1);
        end
        if (pair_end) begin
            send_byte(b, fin_end);
        end
    endtask

    // two-symbol noise gives random mixes of pairs, singles and short runs
    task automatic send_noise(input int len);
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        sym_a = 8'($urandom_range(0, 255));
        sym_b = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            send_byte($urandom_range(0, 1) ? sym_a : sym_b, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic long_run;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single-byte streams at both extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // repeat of two flushed by the final byte
        send_byte(8'haa, 1'b0);
        send_byte(8'haa, 1'b1);
        // literal flushed by the final byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        // pair at the end of a literal, then a repeat flushed
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h34, 1'b1);
        // repeat broken by a new byte, then a literal flushed
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b1);
        // repeat broken by a final byte: held byte flushed as a literal of one
        send_byte(8'h66, 1'b0);
        send_byte(8'h66, 1'b0);
        send_byte(8'h01, 1'b1);

        // full repeat, final byte from empty, then a full literal
        send_repeat(130, 1'b1);
        send_literal(LIT_DEPTH, 1'b0, 1'b0);

        while (sent < ITEMS) begin
            long_run = ($urandom_range(0, 19) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_repeat(long_run ? $urandom_range(120, 135) : $urandom_range(2, 12),
                                $urandom_range(0, 2) == 0);
                end
                4, 5, 6, 7: begin
                    send_literal(long_run ? $urandom_range(120, 130) : $urandom_range(1, 20),
                                 $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
                end
                default: send_noise($urandom_range(1, 10));
            endcase
            if ($urandom_range(0, 5) == 0) begin
                steady = ~steady;
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (queued != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/rle_pkg.sv
hdl/rle_dp.sv
hdl/rle_ctrl.sv
hdl/rle_byte_encoder.sv
tb/rle_byte_encoder_check.sv
tb/rle_byte_encoder_test.sv
